### rtl/es2c_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// es2c_pkg
// Types, constants and tables shared by the epoch-to-calendar pipeline.
// ----------------------------------------------------------------------------
package es2c_pkg;

	typedef struct packed {
		logic [31:0]        unix_seconds;
		logic signed [31:0] micro_in;
	} in_t;

	typedef struct packed {
		logic [7:0]  year_offset;
		logic [3:0]  month_num;
		logic [4:0]  day_num;
		logic [4:0]  hour_num;
		logic [5:0]  minute_num;
		logic [5:0]  second_num;
		logic [19:0] micro_out;
	} out_t;

	// Seconds from 1970-01-01 to 2000-01-01.
	localparam logic [31:0] EPOCH_2000 = 32'd946684800;

	// Microseconds are divided by 64 by a shift, then by 15625. A bias of
	// BIAS_Q * 15625 keeps the dividend positive.
	localparam int unsigned DIV_US      = 15625;
	localparam int unsigned BIAS_Q      = 2148;
	localparam logic [27:0] BIAS_US     = 28'd33562500;
	localparam logic [27:0] RECIP_US    = 28'd140737489;   // ceil(2^41 / 15625)
	localparam int unsigned SHIFT_US    = 41;

	localparam logic [25:0] RECIP_DAY   = 26'd50903317;    // ceil(2^35 / 675)
	localparam int unsigned SHIFT_DAY   = 35;
	localparam logic [17:0] RECIP_HOUR  = 18'd149131;      // ceil(2^29 / 3600)
	localparam int unsigned SHIFT_HOUR  = 29;
	localparam logic [12:0] RECIP_MIN   = 13'd4370;        // ceil(2^18 / 60)
	localparam int unsigned SHIFT_MIN   = 18;
	localparam logic [16:0] RECIP_QUAD  = 17'd91868;       // ceil(2^27 / 1461)
	localparam int unsigned SHIFT_QUAD  = 27;

	localparam int unsigned SECS_DAY    = 86400;
	localparam int unsigned SECS_HOUR   = 3600;
	localparam int unsigned SECS_MIN    = 60;
	localparam int unsigned DAYS_QUAD   = 1461;

	// Day of year on which a month starts, month index 0 is January.
	function automatic logic [8:0] month_start(input logic [3:0] idx, input logic leap);
		logic [8:0] base;
		begin
			unique case (idx)
				4'd0:    base = 9'd0;
				4'd1:    base = 9'd31;
				4'd2:    base = 9'd59;
				4'd3:    base = 9'd90;
				4'd4:    base = 9'd120;
				4'd5:    base = 9'd151;
				4'd6:    base = 9'd181;
				4'd7:    base = 9'd212;
				4'd8:    base = 9'd243;
				4'd9:    base = 9'd273;
				4'd10:   base = 9'd304;
				4'd11:   base = 9'd334;
				default: base = 9'd0;
			endcase
			if (leap && idx >= 4'd2) begin
				base = base + 9'd1;
			end
			return base;
		end
	endfunction

endpackage

### rtl/es2c_micro.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// es2c_micro
// Three stages: floor division of the microsecond offset by one million and
// the carry into the seconds count relative to 2000.
// ----------------------------------------------------------------------------
module es2c_micro (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic              in_valid,
	input  es2c_pkg::in_t     in_item,
	output logic              v_s3,
	output logic [31:0]       t_s3,
	output logic [19:0]       micro_s3
);
	import es2c_pkg::*;

	logic              v_s1, v_s2;
	logic [26:0]       u_s1, u_s2;
	logic [5:0]        lo_s1, lo_s2;
	logic [31:0]       secs_s1, secs_s2;
	logic [54:0]       prod_s2;
	logic [27:0]       u_wide;
	logic [12:0]       qu;
	logic [26:0]       rem_wide;

	assign u_wide   = 28'({{2{in_item.micro_in[31]}}, in_item.micro_in[31:6]}) + BIAS_US;
	assign qu       = prod_s2[53:SHIFT_US];
	assign rem_wide = u_s2 - 27'(qu * 27'(DIV_US));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			u_s1     <= u_wide[26:0];
			lo_s1    <= in_item.micro_in[5:0];
			secs_s1  <= in_item.unix_seconds;
			prod_s2  <= 55'(u_s1) * 55'(RECIP_US);
			u_s2     <= u_s1;
			lo_s2    <= lo_s1;
			secs_s2  <= secs_s1;
			micro_s3 <= {rem_wide[13:0], lo_s2};
			t_s3     <= secs_s2 - EPOCH_2000 + 32'(qu) - 32'(BIAS_Q);
		end
	end

endmodule

### rtl/es2c_date.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// es2c_date
// Four stages: day count to year offset, month and day of month, by way of
// four-year cycles of 1461 days.
// ----------------------------------------------------------------------------
module es2c_date (
	input  logic        clk,
	input  logic        adv,
	input  logic [15:0] days_s5,
	output logic [7:0]  year_s9,
	output logic [3:0]  month_s9,
	output logic [4:0]  day_s9
);
	import es2c_pkg::*;

	logic [32:0] prod_s6;
	logic [15:0] days_s6;
	logic [5:0]  quad_s7;
	logic [10:0] dq_s7;
	logic [7:0]  year_s8;
	logic [8:0]  doy_s8;
	logic        leap_s8;
	logic [5:0]  quad;
	logic [15:0] dq_wide;
	logic [1:0]  yq;
	logic [10:0] ystart;
	logic [3:0]  midx;
	logic [8:0]  doy_off;

	assign quad    = prod_s6[32:SHIFT_QUAD];
	assign dq_wide = days_s6 - 16'(quad * 16'(DAYS_QUAD));

	// The first year of each cycle is the leap year.
	always_comb begin
		priority if (dq_s7 < 11'd366) begin
			yq = 2'd0; ystart = 11'd0;
		end else if (dq_s7 < 11'd731) begin
			yq = 2'd1; ystart = 11'd366;
		end else if (dq_s7 < 11'd1096) begin
			yq = 2'd2; ystart = 11'd731;
		end else begin
			yq = 2'd3; ystart = 11'd1096;
		end
	end

	always_comb begin
		midx = 4'd0;
		for (int i = 1; i < 12; i++) begin
			if (doy_s8 >= month_start(4'(i), leap_s8)) begin
				midx = 4'(i);
			end
		end
		doy_off = doy_s8 - month_start(midx, leap_s8);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s6  <= 33'(days_s5) * 33'(RECIP_QUAD);
			days_s6  <= days_s5;
			quad_s7  <= quad;
			dq_s7    <= dq_wide[10:0];
			year_s8  <= {quad_s7, yq};
			doy_s8   <= 9'(dq_s7 - ystart);
			leap_s8  <= (yq == 2'd0);
			year_s9  <= year_s8;
			month_s9 <= midx + 4'd1;
			day_s9   <= 5'(doy_off + 9'd1);
		end
	end

endmodule

### rtl/es2c_tod.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// es2c_tod
// Six stages: seconds since 2000 into day count, hour, minute and second,
// each division a reciprocal multiply followed by a remainder stage.
// ----------------------------------------------------------------------------
module es2c_tod (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        adv,
	input  logic        v_s3,
	input  logic [31:0] t_s3,
	input  logic [19:0] micro_s3,
	output logic        v_s9,
	output logic [15:0] days_s5,
	output logic [4:0]  hour_s9,
	output logic [5:0]  min_s9,
	output logic [5:0]  sec_s9,
	output logic [19:0] micro_s9
);
	import es2c_pkg::*;

	logic        v_s4, v_s5, v_s6, v_s7, v_s8;
	logic [50:0] prod_s4;
	logic [31:0] t_s4;
	logic [16:0] sod_s5, sod_s6;
	logic [34:0] prod_s6;
	logic [4:0]  hour_s7, hour_s8;
	logic [11:0] remh_s7, remh_s8;
	logic [24:0] prod_s8;
	logic [19:0] micro_s4, micro_s5, micro_s6, micro_s7, micro_s8;
	logic [15:0] days;
	logic [31:0] sod_wide;
	logic [4:0]  hour;
	logic [16:0] remh_wide;
	logic [5:0]  min;
	logic [11:0] sec_wide;

	assign days      = prod_s4[50:SHIFT_DAY];
	assign sod_wide  = t_s4 - 32'(days) * 32'(SECS_DAY);
	assign hour      = prod_s6[33:SHIFT_HOUR];
	assign remh_wide = sod_s6 - 17'(hour * 17'(SECS_HOUR));
	assign min       = prod_s8[23:SHIFT_MIN];
	assign sec_wide  = remh_s8 - 12'(min * 12'(SECS_MIN));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else if (adv) begin
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// The day divisor 86400 is 128 * 675; the low seven bits are dropped.
			prod_s4  <= 51'(t_s3[31:7]) * 51'(RECIP_DAY);
			t_s4     <= t_s3;
			days_s5  <= days;
			sod_s5   <= sod_wide[16:0];
			prod_s6  <= 35'(sod_s5) * 35'(RECIP_HOUR);
			sod_s6   <= sod_s5;
			hour_s7  <= hour;
			remh_s7  <= remh_wide[11:0];
			prod_s8  <= 25'(remh_s7) * 25'(RECIP_MIN);
			hour_s8  <= hour_s7;
			remh_s8  <= remh_s7;
			hour_s9  <= hour_s8;
			min_s9   <= min;
			sec_s9   <= sec_wide[5:0];
			micro_s4 <= micro_s3;
			micro_s5 <= micro_s4;
			micro_s6 <= micro_s5;
			micro_s7 <= micro_s6;
			micro_s8 <= micro_s7;
			micro_s9 <= micro_s8;
		end
	end

endmodule

### rtl/epoch_seconds_to_calendar_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_unit
// Unix seconds plus signed microseconds to calendar date and time since 2000.
// ----------------------------------------------------------------------------
// A nine-stage pipeline that accepts one transaction per cycle while the
// output is not stalled; every division (by one million, a day, an
// hour, a minute and a four-year cycle) is a reciprocal multiply followed by
// a remainder stage, and the result sits in the last stage register until it
// is taken. A stall on the output holds the whole pipeline. Years are counted
// from 2000 with every fourth year a leap year, and times before 2000 wrap
// modulo 2^32 seconds.
module epoch_seconds_to_calendar_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  es2c_pkg::in_t      in_item,
	output logic               out_valid,
	input  logic               out_ready,
	output es2c_pkg::out_t     out_item
);
	import es2c_pkg::*;

	logic        adv;
	logic        v_s3, v_s9;
	logic [31:0] t_s3;
	logic [19:0] micro_s3, micro_s9;
	logic [15:0] days_s5;
	logic [4:0]  hour_s9, day_s9;
	logic [5:0]  min_s9, sec_s9;
	logic [7:0]  year_s9;
	logic [3:0]  month_s9;

	assign adv      = !v_s9 || out_ready;
	assign in_ready = adv;

	es2c_micro u_micro (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (in_valid),
		.in_item  (in_item),
		.v_s3     (v_s3),
		.t_s3     (t_s3),
		.micro_s3 (micro_s3)
	);

	es2c_tod u_tod (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.v_s3     (v_s3),
		.t_s3     (t_s3),
		.micro_s3 (micro_s3),
		.v_s9     (v_s9),
		.days_s5  (days_s5),
		.hour_s9  (hour_s9),
		.min_s9   (min_s9),
		.sec_s9   (sec_s9),
		.micro_s9 (micro_s9)
	);

	es2c_date u_date (
		.clk      (clk),
		.adv      (adv),
		.days_s5  (days_s5),
		.year_s9  (year_s9),
		.month_s9 (month_s9),
		.day_s9   (day_s9)
	);

	assign out_valid = v_s9;

	always_comb begin
		out_item             = '0;
		out_item.year_offset = year_s9;
		out_item.month_num   = month_s9;
		out_item.day_num     = day_s9;
		out_item.hour_num    = hour_s9;
		out_item.minute_num  = min_s9;
		out_item.second_num  = sec_s9;
		out_item.micro_out   = micro_s9;
	end

endmodule

### test/tb_epoch_seconds_to_calendar_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_epoch_seconds_to_calendar_unit
// Checks Unix seconds plus signed microseconds against calendar fields.
// ----------------------------------------------------------------------------
// Directed corner timestamps are sent first, then random ones under three
// idling patterns and one long output stall. Each result is compared with a
// behavioral calendar computation kept in a queue in arrival order.
module tb_epoch_seconds_to_calendar_unit;
	import es2c_pkg::*;

	localparam int WATCHDOG_CYCLES = 20000;
	localparam int DRAIN_CYCLES    = 20;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_t  in_item;
	logic out_valid;
	logic out_ready;
	out_t out_item;

	out_t calendar_q[$];
	int   error_count = 0;
	int   send_idle_pct;
	int   recv_idle_pct;
	bit   hold_output;
	int   idle_cycles = 0;

	epoch_seconds_to_calendar_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic out_t calendar_of(input in_t item);
		out_t        r;
		longint      micro;
		longint      carry;
		longint      rem;
		logic [31:0] t;
		int unsigned days;
		int unsigned yr;
		int unsigned mon;
		int unsigned mlen;
		bit          leap;
		int unsigned lengths[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
		begin
			micro = longint'(item.micro_in);
			carry = micro / 1000000;
			rem   = micro % 1000000;
			if (rem < 0) begin
				rem   = rem + 1000000;
				carry = carry - 1;
			end
			t = item.unix_seconds - 32'd946684800 + 32'(carry);
			r.second_num = 6'(t % 60);
			t = t / 60;
			r.minute_num = 6'(t % 60);
			t = t / 60;
			r.hour_num = 5'(t % 24);
			days = t / 24;
			yr = 0;
			forever begin
				leap = (yr % 4) == 0;
				if (days < (leap ? 366 : 365))
					break;
				days = days - (leap ? 366 : 365);
				yr++;
			end
			mon = 1;
			forever begin
				mlen = lengths[mon - 1] + ((leap && mon == 2) ? 1 : 0);
				if (days < mlen || mon >= 12)
					break;
				days = days - mlen;
				mon++;
			end
			r.year_offset = 8'(yr);
			r.month_num   = 4'(mon);
			r.day_num     = 5'(days + 1);
			r.micro_out   = 20'(rem);
			return r;
		end
	endfunction

	// Sends one transaction; valid stays high across back-to-back items and is
	// dropped only when the sender idles or the run is over.
	task automatic send_timestamp(input logic [31:0] secs, input logic [31:0] micro);
		in_t item;
		begin
			item.unix_seconds = secs;
			item.micro_in     = micro;
			while ($urandom_range(99) < send_idle_pct) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
			in_valid <= 1'b1;
			in_item  <= item;
			@(posedge clk);
			while (!in_ready)
				@(posedge clk);
			calendar_q.push_back(calendar_of(item));
		end
	endtask

	task automatic send_random(input int count);
		logic [31:0] secs;
		logic [31:0] micro;
		begin
			repeat (count) begin
				secs = $urandom;
				case ($urandom_range(3))
					0: micro = $urandom;
					1: micro = 32'($urandom_range(999999));
					2: micro = -32'($urandom_range(3000000));
					default: micro = 32'($urandom_range(4000000)) - 32'd2000000;
				endcase
				send_timestamp(secs, micro);
			end
		end
	endtask

	task automatic test_corners();
		begin
			send_timestamp(32'd946684800, 32'd0);
			send_timestamp(32'd946684800, 32'hFFFF_FFFF);
			send_timestamp(32'd946684799, 32'd0);
			send_timestamp(32'd0, 32'd0);
			send_timestamp(32'hFFFF_FFFF, 32'd999999);
			send_timestamp(32'hFFFF_FFFF, 32'h7FFF_FFFF);
			send_timestamp(32'd0, 32'h8000_0000);
			send_timestamp(32'd946684800, 32'd1000000);
			send_timestamp(32'd946684800, -32'd1000000);
			send_timestamp(32'd946684800, -32'd1000001);
			// Leap day, the last second of the second-to-last day of a leap year, and the first day after.
			send_timestamp(32'd951782400, 32'd0);
			send_timestamp(32'd978220799, 32'd5);
			send_timestamp(32'd978307200, 32'd0);
			// 2100 is treated as a leap year here.
			send_timestamp(32'd4107456000, 32'd0);
			send_timestamp(32'd4107542399, 32'd123456);
			send_timestamp(32'hAAAA_AAAA, 32'h5555_5555);
			send_timestamp(32'h5555_5555, 32'hAAAA_AAAA);
			send_timestamp(32'd1234567890, 32'd500000);
		end
	endtask

	task automatic test_slow_sender();
		begin
			send_idle_pct = 24;
			recv_idle_pct = 81;
			send_random(200);
		end
	endtask

	task automatic test_slow_receiver();
		begin
			send_idle_pct = 81;
			recv_idle_pct = 24;
			send_random(200);
		end
	endtask

	task automatic test_full_rate();
		begin
			send_idle_pct = 0;
			recv_idle_pct = 0;
			send_random(150);
		end
	endtask

	task automatic test_output_backpressure();
		begin
			hold_output = 1'b1;
			send_random(50);
			hold_output = 1'b0;
		end
	endtask

	// The receiver holds off for a long stretch whenever asked.
	initial begin
		int held;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_output) begin
				out_ready <= 1'b0;
				for (held = 0; held < 200; held++)
					@(posedge clk);
				hold_output = 1'b0;
			end
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (calendar_q.size() == 0) begin
				$display("%0t: result with nothing expected, actual %p", $time, out_item);
				error_count++;
			end else begin
				want = calendar_q.pop_front();
				if (out_item !== want) begin
					$display("%0t: mismatch, expected %p, actual %p", $time, want, out_item);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_CYCLES) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_output   = 1'b0;
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		in_item       = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_corners();
		test_output_backpressure();
		test_slow_sender();
		test_slow_receiver();
		test_full_rate();
		in_valid <= 1'b0;
		while (calendar_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
